// File: hw/rtl/lru_slot_replacement_top_macros.svh
// ----------------------------------------------------------------------------
// LRU slot replacement assertion macros
// Shorthand for the concurrent checks in the LRU slot replacement RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_SLOT_REPLACEMENT_TOP_MACROS_SVH
`define LRU_SLOT_REPLACEMENT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUSR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRUSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lrusr_pkg.sv
// ----------------------------------------------------------------------------
// LRU slot replacement package
// Field widths and request and result codes shared by the RTL files.
// ----------------------------------------------------------------------------
`default_nettype none

package lrusr_pkg;

	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam logic MODE_TOUCH = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	localparam status_t ST_TOUCHED = 2'd0;
	localparam status_t ST_TAKEN   = 2'd1;
	localparam status_t ST_EVICTED = 2'd2;
	localparam status_t ST_ERROR   = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/lrusr_req_if.sv
// ----------------------------------------------------------------------------
// LRU slot replacement request channel
// Valid and ready handshake carrying one touch or allocate request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrusr_req_if
	import lrusr_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  mode;
	slot_t slot;

	modport source (output valid, output mode, output slot, input ready);
	modport sink (input valid, input mode, input slot, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lrusr_res_if.sv
// ----------------------------------------------------------------------------
// LRU slot replacement result channel
// Valid and ready handshake carrying the granted slot and its status.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrusr_res_if
	import lrusr_pkg::*;
();
	logic    valid;
	logic    ready;
	slot_t   granted_slot;
	status_t status;

	modport source (output valid, output granted_slot, output status, input ready);
	modport sink (input valid, input granted_slot, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lru_slot_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU slot replacement
// Recency order over cache slots kept as a doubly linked list in two memories.
// ----------------------------------------------------------------------------
// The block keeps the slots in recency order as a linked list whose previous
// and next links live in two single-port-write memories, with head and tail
// in registers. A moving touch and an evicting allocate read links in idle,
// unlink in S_RD, write the slot's links in S_W2 and make it head in S_W3;
// a never-used allocate skips S_RD; a touch error or head-slot touch ends in
// idle. These steps come from the one write port on each link memory, which
// limits the link updates to one entry per memory per cycle. A finished
// result sits in an output register; the block waits for it only when the
// next result is ready before the previous one was taken. The memories need
// no clearing after reset, since only entries of slots handed out are read.
`default_nettype none

`include "lru_slot_replacement_top_macros.svh"

module lru_slot_replacement_top
	import lrusr_pkg::*;
#(
	parameter int NUM_SLOTS = 1024
) (
	input  wire           clk,
	input  wire           arst_n,
	lrusr_req_if.sink     req,
	lrusr_res_if.source   res
);

	localparam int IDX_W  = $clog2(NUM_SLOTS);
	localparam int LINK_W = IDX_W + 1;
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {IDX_W{1'b0}}};
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_SLOTS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_W2   = 3'd2;
	localparam logic [2:0] S_W3   = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [LINK_W-1:0] prev_mem [NUM_SLOTS];
	logic [LINK_W-1:0] next_mem [NUM_SLOTS];

	logic [2:0]        state_q, state_d;
	logic [LINK_W-1:0] head_q, head_d;
	logic [LINK_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  cur_q, cur_d;
	slot_t             pend_slot_q, pend_slot_d;
	status_t           pend_st_q, pend_st_d;
	logic              res_valid_q;
	slot_t             res_slot_q;
	status_t           res_st_q;

	logic [LINK_W-1:0] prev_rd_s1, next_rd_s1;
	logic [IDX_W-1:0]  rd_addr;
	logic              prev_we, next_we;
	logic [IDX_W-1:0]  prev_wa, next_wa;
	logic [LINK_W-1:0] prev_wd, next_wd;

	logic              accept, out_free, finish, res_load;
	logic [CMP_W-1:0]  slot_ext, cnt_ext;
	logic [IDX_W-1:0]  slot_idx, new_idx, tail_idx;
	logic [CMP_W-1:0]  new_ext, tail_ext;
	logic              hit;

	assign req.ready        = (state_q == S_IDLE);
	assign accept           = req.valid && req.ready;
	assign out_free         = !res_valid_q || res.ready;
	assign res.valid        = res_valid_q;
	assign res.granted_slot = res_slot_q;
	assign res.status       = res_st_q;

	assign slot_ext = CMP_W'(req.slot);
	assign cnt_ext  = CMP_W'(cnt_q);
	assign hit      = slot_ext < cnt_ext;
	assign slot_idx = slot_ext[IDX_W-1:0];
	assign new_idx  = cnt_q[IDX_W-1:0];
	assign tail_idx = tail_q[IDX_W-1:0];
	assign new_ext  = CMP_W'(new_idx);
	assign tail_ext = CMP_W'(tail_idx);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		cnt_d       = cnt_q;
		cur_d       = cur_q;
		pend_slot_d = pend_slot_q;
		pend_st_d   = pend_st_q;
		rd_addr     = slot_idx;
		prev_we     = 1'b0;
		next_we     = 1'b0;
		prev_wa     = cur_q;
		next_wa     = cur_q;
		prev_wd     = LINK_NULL;
		next_wd     = LINK_NULL;
		finish      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.mode == MODE_TOUCH) begin
						pend_slot_d = req.slot;
						cur_d       = slot_idx;
						rd_addr     = slot_idx;
						if (!hit) begin
							pend_st_d = ST_ERROR;
							finish    = 1'b1;
						end else if ({1'b0, slot_idx} == head_q) begin
							pend_st_d = ST_TOUCHED;
							finish    = 1'b1;
						end else begin
							pend_st_d = ST_TOUCHED;
							state_d   = S_RD;
						end
					end else if (cnt_q < CNT_FULL) begin
						cur_d       = new_idx;
						pend_slot_d = new_ext[SLOT_W-1:0];
						pend_st_d   = ST_TAKEN;
						state_d     = S_W2;
					end else begin
						cur_d       = tail_idx;
						rd_addr     = tail_idx;
						pend_slot_d = tail_ext[SLOT_W-1:0];
						pend_st_d   = ST_EVICTED;
						if (tail_q == head_q) begin
							finish = 1'b1;
						end else begin
							state_d = S_RD;
						end
					end
				end
			end
			S_RD: begin
				next_we = 1'b1;
				next_wa = prev_rd_s1[IDX_W-1:0];
				next_wd = next_rd_s1;
				if (!next_rd_s1[LINK_W-1]) begin
					prev_we = 1'b1;
					prev_wa = next_rd_s1[IDX_W-1:0];
					prev_wd = prev_rd_s1;
				end else begin
					tail_d = prev_rd_s1;
				end
				state_d = S_W2;
			end
			S_W2: begin
				prev_we = 1'b1;
				prev_wa = cur_q;
				prev_wd = LINK_NULL;
				next_we = 1'b1;
				next_wa = cur_q;
				next_wd = head_q;
				state_d = S_W3;
			end
			S_W3: begin
				if (!head_q[LINK_W-1]) begin
					prev_we = 1'b1;
					prev_wa = head_q[IDX_W-1:0];
					prev_wd = {1'b0, cur_q};
				end else begin
					tail_d = {1'b0, cur_q};
				end
				head_d = {1'b0, cur_q};
				if (pend_st_q == ST_TAKEN) begin
					cnt_d = cnt_q + CNT_W'(1);
				end
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			S_DONE: begin
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (finish && !out_free) begin
			state_d = S_DONE;
		end
	end

	assign res_load = finish && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= LINK_NULL;
			tail_q      <= LINK_NULL;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		pend_slot_q <= pend_slot_d;
		pend_st_q   <= pend_st_d;
		if (res_load) begin
			res_slot_q <= pend_slot_d;
			res_st_q   <= pend_st_d;
		end
	end

	always_ff @(posedge clk) begin
		prev_rd_s1 <= prev_mem[rd_addr];
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
	end

	always_ff @(posedge clk) begin
		next_rd_s1 <= next_mem[rd_addr];
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
	end

	`LRUSR_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_FULL, "slot count exceeds the slot total")
	`LRUSR_ASSERT_SAME(a_head_empty, state_q == S_IDLE, (cnt_q == '0) == head_q[LINK_W-1], "head null disagrees with empty list")
	`LRUSR_ASSERT_SAME(a_tail_head, state_q == S_IDLE, head_q[LINK_W-1] == tail_q[LINK_W-1], "head and tail disagree on empty list")
	`LRUSR_ASSERT_SAME(a_no_overwrite, res_load, !res_valid_q || res.ready, "result overwritten before it was taken")
	`LRUSR_ASSERT_NEXT(a_evict_full, res_load && (pend_st_d == ST_EVICTED), cnt_q == CNT_FULL, "eviction while slots remain unused")

endmodule

`default_nettype wire
